### rtl/assert_macros.svh
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BFFA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bffa assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define BFFA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bffa assertion failed");

`endif

### rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared widths, codes and default parameters of the best-fit allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  // beat payload widths
  localparam int REQ_SIZE_W = 24;
  localparam int ADDR_W     = 23;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int NEED_W     = 22;

  // granule is 8 bytes, page is 512 granules
  localparam int GRAN_SHIFT      = 3;
  localparam int PAGE_GRAN_SHIFT = 9;

  // default sizing
  localparam int DEF_MAX_FREE_SEGMENTS = 64;
  localparam int DEF_MAX_USED_BLOCKS   = 64;
  localparam int DEF_HEADER_UNITS      = 2;
  localparam int DEF_MAX_REGION_PAGES  = 2048;
  localparam logic [CFG_DATA_W-1:0] RESET_REGION_PAGES = 12'd16;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd5;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd1;

  localparam logic [1:0] POLICY_BEST = 2'd0;

endpackage

### rtl/bffa_req_if.sv
// ----------------------------------------------------------------------------
// bffa_req_if
// Request channel: allocate or free beat with valid/ready.
// ----------------------------------------------------------------------------
interface bffa_req_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [bffa_pkg::REQ_SIZE_W-1:0]   request_size;
  logic [bffa_pkg::ADDR_W-1:0]       block_address;

  modport source (output valid, mode, request_size, block_address, input ready);
  modport sink   (input valid, mode, request_size, block_address, output ready);
endinterface

### rtl/bffa_rsp_if.sv
// ----------------------------------------------------------------------------
// bffa_rsp_if
// Result channel: status and payload offset with valid/ready.
// ----------------------------------------------------------------------------
interface bffa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [bffa_pkg::STATUS_W-1:0]   status;
  logic [bffa_pkg::ADDR_W-1:0]     address;

  modport source (output valid, status, address, input ready);
  modport sink   (input valid, status, address, output ready);
endinterface

### rtl/bffa_cfg_if.sv
// ----------------------------------------------------------------------------
// bffa_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface bffa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bffa_pkg::CFG_IDX_W-1:0]    index;
  logic [bffa_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/best_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_core
// Best-fit allocator with coalescing over a page-rounded region.
// ----------------------------------------------------------------------------
// One request is handled at a time. The free table and the used table each
// sit in a single-port-write, registered-read memory, and a small sequencer
// walks them one entry per cycle. An allocate scans the live free segments,
// then shifts the table when the whole best-fit segment is taken; a free
// scans the live used blocks and then the free table, and shifts the table
// for an insert or a double merge. Rejected requests go straight from idle
// to the result state. After reset or a region_pages write the free table is
// rebuilt as a single segment before requests are taken.
// The result sits in an output register, so the core does not wait on it
// until the next result is ready.
module best_fit_free_list_allocator_core #(
  parameter int MAX_FREE_SEGMENTS = bffa_pkg::DEF_MAX_FREE_SEGMENTS,
  parameter int MAX_USED_BLOCKS   = bffa_pkg::DEF_MAX_USED_BLOCKS,
  parameter int HEADER_UNITS      = bffa_pkg::DEF_HEADER_UNITS,
  parameter int MAX_REGION_PAGES  = bffa_pkg::DEF_MAX_REGION_PAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  bffa_req_if.sink    in_req,
  bffa_rsp_if.source  out_rsp,
  bffa_cfg_if.sink    cfg_wr
);
  import bffa_pkg::*;

  // table widths
  localparam int LW   = $clog2(MAX_REGION_PAGES * 512 + 1);
  localparam int SW   = $clog2(MAX_REGION_PAGES * 512);
  localparam int CW   = (LW > NEED_W) ? LW : NEED_W;
  localparam int FCW  = $clog2(MAX_FREE_SEGMENTS + 1);
  localparam int UCW  = $clog2(MAX_USED_BLOCKS + 1);
  localparam int FIW  = (MAX_FREE_SEGMENTS > 1) ? $clog2(MAX_FREE_SEGMENTS) : 1;
  localparam int UIW  = (MAX_USED_BLOCKS > 1) ? $clog2(MAX_USED_BLOCKS) : 1;
  localparam int CNTW = (FCW > UCW) ? FCW : UCW;
  localparam int IW   = (FIW > UIW) ? FIW : UIW;
  localparam int HSW  = SW + 4;
  localparam int MW   = ((HSW + GRAN_SHIFT) > ADDR_W) ? (HSW + GRAN_SHIFT) : ADDR_W;
  localparam int RSW  = REQ_SIZE_W + 1;

  typedef struct packed {
    logic [SW-1:0] start;
    logic [LW-1:0] len;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ASCAN, S_APLACE, S_SHIFT, S_USCAN, S_FSCAN, S_FPLACE,
    S_FINS, S_UREAD, S_UWRITE, S_RESP
  } state_t;

  // registers
  state_t                  state_r, state_nxt, after_r, after_nxt;
  logic                    init_pend_r, init_pend_nxt;
  logic [CFG_DATA_W-1:0]   region_r, region_nxt;
  logic [1:0]              policy_r, policy_nxt;
  logic [FCW-1:0]          fcount_r, fcount_nxt;
  logic [UCW-1:0]          ucount_r, ucount_nxt;
  logic [NEED_W-1:0]       need_r, need_nxt;
  logic [ADDR_W-1:0]       baddr_r, baddr_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [IW-1:0]           pend_idx_r, pend_idx_nxt;
  logic                    found_r, found_nxt;
  logic [FIW-1:0]          best_idx_r, best_idx_nxt;
  logic [UIW-1:0]          uidx_r, uidx_nxt;
  seg_t                    seg_r, seg_nxt;
  logic [FCW-1:0]          pos_r, pos_nxt;
  seg_t                    prev_r, prev_nxt;
  seg_t                    next_r, next_nxt;
  logic                    next_found_r, next_found_nxt;
  logic [FCW-1:0]          rem_r, rem_nxt;
  logic [FIW-1:0]          src_r, src_nxt;
  logic                    shift_up_r, shift_up_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]       res_addr_r, res_addr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]       out_addr_r, out_addr_nxt;

  // memories
  seg_t                    fmem [MAX_FREE_SEGMENTS];
  seg_t                    umem [MAX_USED_BLOCKS];
  seg_t                    fq_r, uq_r;
  logic [FIW-1:0]          f_raddr, f_waddr;
  logic                    f_we;
  seg_t                    f_wdata;
  logic [UIW-1:0]          u_raddr, u_waddr;
  logic                    u_we;
  seg_t                    u_wdata;

  // datapath helpers
  logic                    in_acc;
  logic [CFG_DATA_W-1:0]   cfg_pages;
  logic [LW-1:0]           init_len;
  logic                    f_issue, u_issue;
  logic [LW-1:0]           split_diff;
  logic [HSW-1:0]          hdr_gran;
  logic [MW-1:0]           ent_addr;
  logic                    merge_prev, merge_next;

  assign in_acc        = in_req.valid && in_req.ready;
  assign in_req.ready  = (state_r == S_IDLE) && !init_pend_r;
  assign cfg_wr.ready  = 1'b1;
  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.status = out_status_r;
  assign out_rsp.address = out_addr_r;

  // clamp written page count into range
  always_comb begin
    cfg_pages = cfg_wr.data;
    if (cfg_wr.data == '0) begin
      cfg_pages = CFG_DATA_W'(1);
    end else if (32'(cfg_wr.data) > MAX_REGION_PAGES) begin
      cfg_pages = CFG_DATA_W'(MAX_REGION_PAGES);
    end
  end

  assign init_len   = LW'(region_r) << PAGE_GRAN_SHIFT;
  assign f_issue    = cnt_r < CNTW'(fcount_r);
  assign u_issue    = cnt_r < CNTW'(ucount_r);
  assign split_diff = seg_r.len - LW'(need_r);

  // payload offset of a block start; shared by allocate and used scan
  always_comb begin
    if (state_r == S_USCAN) begin
      hdr_gran = HSW'(uq_r.start) + HSW'(HEADER_UNITS);
    end else begin
      hdr_gran = HSW'(seg_r.start) + HSW'(HEADER_UNITS);
    end
    ent_addr = MW'(hdr_gran) << GRAN_SHIFT;
  end

  assign merge_prev = (pos_r != '0) &&
    ((LW + 1)'(prev_r.start) + (LW + 1)'(prev_r.len) == (LW + 1)'(seg_r.start));
  assign merge_next = next_found_r &&
    ((LW + 1)'(seg_r.start) + (LW + 1)'(seg_r.len) == (LW + 1)'(next_r.start));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    after_nxt      = after_r;
    init_pend_nxt  = init_pend_r;
    region_nxt     = region_r;
    policy_nxt     = policy_r;
    fcount_nxt     = fcount_r;
    ucount_nxt     = ucount_r;
    need_nxt       = need_r;
    baddr_nxt      = baddr_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    uidx_nxt       = uidx_r;
    seg_nxt        = seg_r;
    pos_nxt        = pos_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    next_found_nxt = next_found_r;
    rem_nxt        = rem_r;
    src_nxt        = src_r;
    shift_up_nxt   = shift_up_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    f_raddr = '0;
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    u_raddr = '0;
    u_we    = 1'b0;
    u_waddr = '0;
    u_wdata = '0;

    case (state_r)
      S_IDLE: begin
        // rebuild the single free segment
        if (init_pend_r) begin
          f_we          = 1'b1;
          f_waddr       = '0;
          f_wdata.start = '0;
          f_wdata.len   = init_len;
          init_pend_nxt = 1'b0;
        end
        if (in_acc) begin
          res_addr_nxt = '0;
          cnt_nxt      = '0;
          found_nxt    = 1'b0;
          state_nxt    = S_RESP;
          if (in_req.mode == MODE_ALLOC) begin
            need_nxt = NEED_W'((RSW'(in_req.request_size) + RSW'(7))
                         >> GRAN_SHIFT) + NEED_W'(HEADER_UNITS);
            if (policy_r != POLICY_BEST || in_req.request_size == '0) begin
              res_status_nxt = ST_REJECT;
            end else if (ucount_r == UCW'(MAX_USED_BLOCKS)) begin
              res_status_nxt = ST_FULL;
            end else begin
              state_nxt = S_ASCAN;
            end
          end else begin
            baddr_nxt = in_req.block_address;
            if (in_req.block_address == '0) begin
              res_status_nxt = ST_FREED;
            end else begin
              state_nxt = S_USCAN;
            end
          end
        end
      end

      S_ASCAN: begin
        // best-fit scan, one entry per cycle
        if (f_issue) begin
          f_raddr      = FIW'(cnt_r);
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = IW'(cnt_r);
          cnt_nxt      = cnt_r + CNTW'(1);
        end
        if (pend_v_r && CW'(fq_r.len) >= CW'(need_r) &&
            (!found_r || fq_r.len < seg_r.len)) begin
          found_nxt    = 1'b1;
          best_idx_nxt = FIW'(pend_idx_r);
          seg_nxt      = fq_r;
        end
        if (!f_issue && !pend_v_r) begin
          if (found_r) begin
            state_nxt = S_APLACE;
          end else begin
            res_status_nxt = ST_NOFIT;
            state_nxt      = S_RESP;
          end
        end
      end

      S_APLACE: begin
        u_we           = 1'b1;
        u_waddr        = UIW'(ucount_r);
        u_wdata.start  = seg_r.start;
        ucount_nxt     = ucount_r + UCW'(1);
        res_status_nxt = ST_ALLOC;
        res_addr_nxt   = ADDR_W'(ent_addr);
        if (split_diff >= LW'(HEADER_UNITS + 1)) begin
          // split: low part becomes the block
          u_wdata.len   = LW'(need_r);
          f_we          = 1'b1;
          f_waddr       = best_idx_r;
          f_wdata.start = seg_r.start + SW'(need_r);
          f_wdata.len   = split_diff;
          state_nxt     = S_RESP;
        end else begin
          // whole segment taken; close the gap
          u_wdata.len  = seg_r.len;
          rem_nxt      = fcount_r - FCW'(1) - FCW'(best_idx_r);
          src_nxt      = FIW'(FCW'(best_idx_r) + FCW'(1));
          shift_up_nxt = 1'b0;
          fcount_nxt   = fcount_r - FCW'(1);
          after_nxt    = S_RESP;
          state_nxt    = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // move entries one place: read an entry, write it in the next cycle
        if (rem_r != '0) begin
          f_raddr    = src_r;
          pend_v_nxt = 1'b1;
          if (shift_up_r) begin
            pend_idx_nxt = IW'(src_r + FIW'(1));
            src_nxt      = src_r - FIW'(1);
          end else begin
            pend_idx_nxt = IW'(src_r - FIW'(1));
            src_nxt      = src_r + FIW'(1);
          end
          rem_nxt = rem_r - FCW'(1);
        end
        if (pend_v_r) begin
          f_we    = 1'b1;
          f_waddr = FIW'(pend_idx_r);
          f_wdata = fq_r;
        end
        if (rem_r == '0 && !pend_v_r) begin
          state_nxt = after_r;
        end
      end

      S_USCAN: begin
        // look the payload offset up in the used table
        if (u_issue) begin
          u_raddr      = UIW'(cnt_r);
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = IW'(cnt_r);
          cnt_nxt      = cnt_r + CNTW'(1);
        end
        if (pend_v_r && !found_r && ent_addr == MW'(baddr_r)) begin
          found_nxt = 1'b1;
          uidx_nxt  = UIW'(pend_idx_r);
          seg_nxt   = uq_r;
        end
        if (!u_issue && !pend_v_r) begin
          if (found_r) begin
            cnt_nxt        = '0;
            pos_nxt        = '0;
            next_found_nxt = 1'b0;
            state_nxt      = S_FSCAN;
          end else begin
            res_status_nxt = ST_UNKNOWN;
            state_nxt      = S_RESP;
          end
        end
      end

      S_FSCAN: begin
        // find insertion point and both neighbours
        if (f_issue) begin
          f_raddr    = FIW'(cnt_r);
          pend_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNTW'(1);
        end
        if (pend_v_r) begin
          if (fq_r.start < seg_r.start) begin
            pos_nxt  = pos_r + FCW'(1);
            prev_nxt = fq_r;
          end else if (!next_found_r) begin
            next_nxt       = fq_r;
            next_found_nxt = 1'b1;
          end
        end
        if (!f_issue && !pend_v_r) begin
          state_nxt = S_FPLACE;
        end
      end

      S_FPLACE: begin
        after_nxt = S_UREAD;
        if (merge_prev && merge_next) begin
          f_we          = 1'b1;
          f_waddr       = FIW'(pos_r - FCW'(1));
          f_wdata.start = prev_r.start;
          f_wdata.len   = prev_r.len + seg_r.len + next_r.len;
          rem_nxt       = fcount_r - FCW'(1) - pos_r;
          src_nxt       = FIW'(pos_r + FCW'(1));
          shift_up_nxt  = 1'b0;
          fcount_nxt    = fcount_r - FCW'(1);
          state_nxt     = S_SHIFT;
        end else if (merge_prev) begin
          f_we          = 1'b1;
          f_waddr       = FIW'(pos_r - FCW'(1));
          f_wdata.start = prev_r.start;
          f_wdata.len   = prev_r.len + seg_r.len;
          state_nxt     = S_UREAD;
        end else if (merge_next) begin
          f_we          = 1'b1;
          f_waddr       = FIW'(pos_r);
          f_wdata.start = seg_r.start;
          f_wdata.len   = next_r.len + seg_r.len;
          state_nxt     = S_UREAD;
        end else if (fcount_r == FCW'(MAX_FREE_SEGMENTS)) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          rem_nxt      = fcount_r - pos_r;
          src_nxt      = FIW'(fcount_r - FCW'(1));
          shift_up_nxt = 1'b1;
          after_nxt    = S_FINS;
          state_nxt    = S_SHIFT;
        end
      end

      S_FINS: begin
        f_we       = 1'b1;
        f_waddr    = FIW'(pos_r);
        f_wdata    = seg_r;
        fcount_nxt = fcount_r + FCW'(1);
        state_nxt  = S_UREAD;
      end

      S_UREAD: begin
        // last used entry fills the hole
        u_raddr   = UIW'(ucount_r - UCW'(1));
        state_nxt = S_UWRITE;
      end

      S_UWRITE: begin
        u_we           = 1'b1;
        u_waddr        = uidx_r;
        u_wdata        = uq_r;
        ucount_nxt     = ucount_r - UCW'(1);
        res_status_nxt = ST_FREED;
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_REGION: begin
          region_nxt    = cfg_pages;
          fcount_nxt    = FCW'(1);
          ucount_nxt    = '0;
          init_pend_nxt = 1'b1;
        end
        CFG_POLICY: begin
          policy_nxt = cfg_wr.data[1:0];
        end
        default: begin
          policy_nxt = policy_r;
        end
      endcase
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_IDLE;
      init_pend_r <= 1'b1;
      region_r    <= RESET_REGION_PAGES;
      policy_r    <= POLICY_BEST;
      fcount_r    <= FCW'(1);
      ucount_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      init_pend_r <= init_pend_nxt;
      region_r    <= region_nxt;
      policy_r    <= policy_nxt;
      fcount_r    <= fcount_nxt;
      ucount_r    <= ucount_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    need_r       <= need_nxt;
    baddr_r      <= baddr_nxt;
    cnt_r        <= cnt_nxt;
    pend_idx_r   <= pend_idx_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    uidx_r       <= uidx_nxt;
    seg_r        <= seg_nxt;
    pos_r        <= pos_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    next_found_r <= next_found_nxt;
    rem_r        <= rem_nxt;
    src_r        <= src_nxt;
    shift_up_r   <= shift_up_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  // free segment table
  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_waddr] <= f_wdata;
    end
    fq_r <= fmem[f_raddr];
  end

  // used block table
  always_ff @(posedge clk) begin
    if (u_we) begin
      umem[u_waddr] <= u_wdata;
    end
    uq_r <= umem[u_raddr];
  end

endmodule

### rtl/bffa_checker.sv
// ----------------------------------------------------------------------------
// bffa_port_checker
// Port-level checks on the allocator core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bffa_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bffa_pkg::STATUS_W-1:0]   out_status,
  input logic [bffa_pkg::ADDR_W-1:0]     out_address
);
  import bffa_pkg::*;

  // status code stays in the defined range
  `BFFA_ASSERT(a_status_range, clk, rst_n, !out_valid || out_status <= ST_UNKNOWN)
  // only an allocation carries an offset
  `BFFA_ASSERT(a_addr_zero, clk, rst_n, !out_valid || out_status == ST_ALLOC || out_address == '0)
  // one request at a time: busy right after a beat is taken
  `BFFA_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)
  // stalled result holds
  `BFFA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_status) && $stable(out_address))

endmodule

bind best_fit_free_list_allocator_core bffa_port_checker u_bffa_port_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_status  (out_rsp.status),
  .out_address (out_rsp.address)
);
